/* sv/vn4_pkg.sv */
// ----------------------------------------------------------------------------
// vn4_pkg
// Shared types and constants for the four-component vector normalizer.
// ----------------------------------------------------------------------------
package vn4_pkg;

   localparam int CompWidth = 16;
   localparam int FracBits  = 14;
   localparam int NormWidth = FracBits + 2;

   // front stages, search stages (one per quotient bit), output register
   localparam int Latency   = 3 + (FracBits + 1) + 1;

   typedef struct packed {
      logic signed [CompWidth-1:0] comp_x;
      logic signed [CompWidth-1:0] comp_y;
      logic signed [CompWidth-1:0] comp_z;
      logic signed [CompWidth-1:0] comp_w;
   } req_type;

   typedef struct packed {
      logic signed [NormWidth-1:0] norm_x;
      logic signed [NormWidth-1:0] norm_y;
      logic signed [NormWidth-1:0] norm_z;
      logic signed [NormWidth-1:0] norm_w;
      logic                        zero_vector;
   } rsp_type;

endpackage

/* sv/vector4_normalize_core.sv */
// ----------------------------------------------------------------------------
// vector4_normalize_core
// Four-component vector normalizer, signed Q2.14 result.
// ----------------------------------------------------------------------------
// throughput: one item per cycle, busy is always low
// the four lane search pipelines, one stage per quotient bit, set the latency
// reset clears only the valid pipeline; the receiver cannot stall
module vector4_normalize_core #(
   parameter int COMP_WIDTH = vn4_pkg::CompWidth,
   parameter int FRAC_BITS  = vn4_pkg::FracBits
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  vn4_pkg::req_type  req_item,
   output logic              rsp_strobe,
   output vn4_pkg::rsp_type  rsp_item
);
   import vn4_pkg::*;

   localparam int QW  = FRAC_BITS + 1;
   localparam int OW  = FRAC_BITS + 2;
   localparam int Lat = 3 + (FRAC_BITS + 1) + 1;
   localparam int Gap = FRAC_BITS + 1;

   logic [3:0][COMP_WIDTH-1:0]   comp;
   logic [3:0][2*COMP_WIDTH-1:0] sq;
   logic [3:0]                   neg;
   logic [2*COMP_WIDTH:0]        sum;
   logic                         zero;
   logic [QW-1:0]                lane_q [4];
   logic [3:0]                   lane_neg;
   logic [Gap-1:0]               zero_ff;
   logic [Lat-1:0]               vld_ff;
   logic [Lat-1:0]               vld_in;
   logic [3:0][OW-1:0]           norm_in;
   logic [3:0][OW-1:0]           norm_ff;
   logic                         zflag_ff;

   assign comp[0] = COMP_WIDTH'(req_item.comp_x);
   assign comp[1] = COMP_WIDTH'(req_item.comp_y);
   assign comp[2] = COMP_WIDTH'(req_item.comp_z);
   assign comp[3] = COMP_WIDTH'(req_item.comp_w);

   assign busy = 1'b0;

   vn4_front #(.COMP_WIDTH(COMP_WIDTH)) u_front (
      .clock (clock),
      .comp  (comp),
      .sq    (sq),
      .neg   (neg),
      .sum   (sum),
      .zero  (zero)
   );

   for (genvar l = 0; l < 4; l++) begin : g_lane
      vn4_lane #(.COMP_WIDTH(COMP_WIDTH), .FRAC_BITS(FRAC_BITS)) u_lane (
         .clock (clock),
         .sq    (sq[l]),
         .sum   (sum),
         .neg   (neg[l]),
         .q     (lane_q[l]),
         .q_neg (lane_neg[l])
      );
   end

   // zero flag travels beside the lanes
   always_ff @(posedge clock) begin
      zero_ff <= {zero_ff[Gap-2:0], zero};
   end

   // valid pipeline
   assign vld_in = {vld_ff[Lat-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // merge lanes: sign, zero vector override
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         if (zero_ff[Gap-1]) begin
            norm_in[i] = '0;
         end else if (lane_neg[i]) begin
            norm_in[i] = ~OW'(lane_q[i]) + 1'b1;
         end else begin
            norm_in[i] = OW'(lane_q[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      norm_ff  <= norm_in;
      zflag_ff <= zero_ff[Gap-1];
   end

   assign rsp_strobe           = vld_ff[Lat-1];
   assign rsp_item.norm_x      = NormWidth'(norm_ff[0]);
   assign rsp_item.norm_y      = NormWidth'(norm_ff[1]);
   assign rsp_item.norm_z      = NormWidth'(norm_ff[2]);
   assign rsp_item.norm_w      = NormWidth'(norm_ff[3]);
   assign rsp_item.zero_vector = zflag_ff;

endmodule

/* sv/vn4_front.sv */
// ----------------------------------------------------------------------------
// vn4_front
// Magnitudes, squares and sum of squares of the four components.
// ----------------------------------------------------------------------------
module vn4_front #(
   parameter int COMP_WIDTH = vn4_pkg::CompWidth
) (
   input  logic                               clock,
   input  logic [3:0][COMP_WIDTH-1:0]         comp,
   output logic [3:0][2*COMP_WIDTH-1:0]       sq,
   output logic [3:0]                         neg,
   output logic [2*COMP_WIDTH:0]              sum,
   output logic                               zero
);
   import vn4_pkg::*;

   localparam int SqWidth  = 2 * COMP_WIDTH;
   localparam int SumWidth = 2 * COMP_WIDTH + 1;

   logic [3:0][COMP_WIDTH-1:0] mag_ff;
   logic [3:0]                 neg1_ff;
   logic [3:0][SqWidth-1:0]    sq2_ff;
   logic [3:0]                 neg2_ff;
   logic [3:0][SqWidth-1:0]    sq3_ff;
   logic [3:0]                 neg3_ff;
   logic [SumWidth-1:0]        sum_ff;
   logic [SumWidth-1:0]        sum_in;
   logic                       zero_ff;

   // magnitude, the most negative value keeps its exact size unsigned
   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         neg1_ff[i] <= comp[i][COMP_WIDTH-1];
         mag_ff[i]  <= comp[i][COMP_WIDTH-1] ? (~comp[i] + 1'b1) : comp[i];
      end
   end

   // one square per lane
   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         sq2_ff[i] <= SqWidth'(mag_ff[i]) * SqWidth'(mag_ff[i]);
      end
      neg2_ff <= neg1_ff;
   end

   // sum of squares
   always_comb begin
      sum_in = '0;
      for (int i = 0; i < 4; i++) begin
         sum_in = sum_in + SumWidth'(sq2_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      sum_ff  <= sum_in;
      sq3_ff  <= sq2_ff;
      neg3_ff <= neg2_ff;
      zero_ff <= (sum_in == '0);
   end

   assign sq   = sq3_ff;
   assign neg  = neg3_ff;
   assign sum  = sum_ff;
   assign zero = zero_ff;

endmodule

/* sv/vn4_lane.sv */
// ----------------------------------------------------------------------------
// vn4_lane
// Pipelined bit-by-bit search for the largest q with q*q*S <= a*a*2^(2F).
// ----------------------------------------------------------------------------
module vn4_lane #(
   parameter int COMP_WIDTH = vn4_pkg::CompWidth,
   parameter int FRAC_BITS  = vn4_pkg::FracBits
) (
   input  logic                      clock,
   input  logic [2*COMP_WIDTH-1:0]   sq,
   input  logic [2*COMP_WIDTH:0]     sum,
   input  logic                      neg,
   output logic [FRAC_BITS:0]        q,
   output logic                      q_neg
);
   import vn4_pkg::*;

   localparam int PW     = 2 * COMP_WIDTH + 2 * FRAC_BITS + 3;
   localparam int QW     = FRAC_BITS + 1;
   localparam int Stages = FRAC_BITS + 1;

   // stage inputs, index 0 is the lane input
   logic [PW-1:0] st_p [Stages+1];
   logic [PW-1:0] st_t [Stages+1];
   logic [PW-1:0] st_r [Stages+1];
   logic [PW-1:0] st_s [Stages+1];
   logic [QW-1:0] st_q [Stages+1];
   logic          st_n [Stages+1];

   assign st_p[0] = '0;
   assign st_t[0] = '0;
   assign st_q[0] = '0;
   assign st_r[0] = PW'(sq) << (2 * FRAC_BITS);
   assign st_s[0] = PW'(sum);
   assign st_n[0] = neg;

   for (genvar g = 0; g < Stages; g++) begin : g_stage
      localparam int K = FRAC_BITS - g;

      logic [PW-1:0] cand_in;
      logic          fits_in;
      logic [PW-1:0] p_ff, t_ff, r_ff, s_ff;
      logic [QW-1:0] q_ff;
      logic          n_ff;

      // (q + 2^k)^2 S = q^2 S + 2^(k+1) q S + 2^(2k) S
      assign cand_in = st_p[g] + (st_t[g] << (K + 1)) + (st_s[g] << (2 * K));
      assign fits_in = (cand_in <= st_r[g]);

      always_ff @(posedge clock) begin
         p_ff    <= fits_in ? cand_in : st_p[g];
         t_ff    <= fits_in ? (st_t[g] + (st_s[g] << K)) : st_t[g];
         q_ff    <= st_q[g] | (QW'(fits_in) << K);
         r_ff    <= st_r[g];
         s_ff    <= st_s[g];
         n_ff    <= st_n[g];
      end

      assign st_p[g+1] = p_ff;
      assign st_t[g+1] = t_ff;
      assign st_q[g+1] = q_ff;
      assign st_r[g+1] = r_ff;
      assign st_s[g+1] = s_ff;
      assign st_n[g+1] = n_ff;
   end

   assign q     = st_q[Stages];
   assign q_neg = st_n[Stages];

endmodule

/* sv/vn4_check.sv */
// ----------------------------------------------------------------------------
// vn4_check
// Port-level checks for the vector normalizer, bound to the top level.
// ----------------------------------------------------------------------------
module vn4_check (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input vn4_pkg::req_type  req_item,
   input logic              rsp_strobe,
   input vn4_pkg::rsp_type  rsp_item
);
   import vn4_pkg::*;

   localparam int OneQ = 1 << FracBits;

   logic req_zero;

   assign req_zero = (req_item.comp_x == '0) && (req_item.comp_y == '0)
                  && (req_item.comp_z == '0) && (req_item.comp_w == '0);

   // every result comes from an item taken a fixed latency earlier
   a_strobe_src: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, Latency))
      else $error("result without a matching item");

   // a zero vector item comes back flagged
   a_zero_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && $past(req_zero, Latency) |-> rsp_item.zero_vector)
      else $error("zero vector not flagged");

   // flagged results carry all-zero components
   a_zero_out: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.zero_vector |->
         (rsp_item.norm_x == '0) && (rsp_item.norm_y == '0)
         && (rsp_item.norm_z == '0) && (rsp_item.norm_w == '0))
      else $error("zero vector with nonzero components");

   // the x and w components stay within unit range
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (int'(rsp_item.norm_x) <= OneQ) && (int'(rsp_item.norm_x) >= -OneQ)
         && (int'(rsp_item.norm_w) <= OneQ) && (int'(rsp_item.norm_w) >= -OneQ))
      else $error("component outside unit range");

endmodule

bind vector4_normalize_core vn4_check u_vn4_check (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_item   (req_item),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);
